@@ rtl/sfs_pkg.sv @@
// sfs_pkg: shared types, codes and constants of the sprite frame sequencer
// no dependencies; used by the channel interfaces and every rtl module
package sfs_pkg;

	// field widths fixed by the sprite sheet format
	localparam int unsigned FRAME_W  = 9;
	localparam int unsigned WIDTH_W  = 10;
	localparam int unsigned ROW_W    = 16;
	localparam int unsigned DELAY_W  = 16;
	localparam int unsigned SRC_X_W  = 20;
	localparam int unsigned CMD_W    = 2;
	localparam int unsigned DIR_W    = 3;
	localparam int unsigned PICK_W   = 2;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// default animation length limit
	localparam int unsigned MAX_FRAMES_DEF = 256;

	// command codes
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK      = 2'd0,
		CMD_SET_FRAME = 2'd1,
		CMD_RESTART   = 2'd2,
		CMD_SET_DIR   = 2'd3
	} cmd_t;

	// animation modes
	typedef enum logic [1:0] {
		MODE_LOOP     = 2'd0,
		MODE_PINGPONG = 2'd1,
		MODE_ONCE     = 2'd2,
		MODE_STATIC   = 2'd3
	} mode_t;

	// facing, also the encoding of the random pick
	typedef enum logic [PICK_W-1:0] {
		FACE_UP    = 2'd0,
		FACE_LEFT  = 2'd1,
		FACE_DOWN  = 2'd2,
		FACE_RIGHT = 2'd3
	} facing_t;

	// direction code that selects the random pick
	localparam logic [DIR_W-1:0] DIR_FROM_PICK = 3'd4;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_ANIM_CONTROL = 3'd1,
		REG_FRAME_COUNT  = 3'd2,
		REG_DELAY_TICKS  = 3'd3,
		REG_ROW_UP       = 3'd4,
		REG_ROW_DOWN     = 3'd5,
		REG_ROW_LEFT     = 3'd6,
		REG_ROW_RIGHT    = 3'd7
	} reg_idx_t;

	// configuration as seen by the animation core
	typedef struct packed {
		logic [WIDTH_W-1:0] frame_width;
		mode_t              mode;
		logic               walk;
		logic [FRAME_W-1:0] frame_count;
		logic [DELAY_W-1:0] delay_ticks;
		logic [ROW_W-1:0]   row_up;
		logic [ROW_W-1:0]   row_down;
		logic [ROW_W-1:0]   row_left;
		logic [ROW_W-1:0]   row_right;
	} cfg_t;

endpackage

@@ rtl/sfs_cmd_if.sv @@
// sfs_cmd_if: command channel of the sprite frame sequencer
// depends on sfs_pkg for the field widths
interface sfs_cmd_if;
	logic                             valid;
	logic                             ready;
	logic [sfs_pkg::CMD_W-1:0]        command;
	logic [sfs_pkg::FRAME_W-1:0]      frame_value;
	logic [sfs_pkg::DIR_W-1:0]        direction;
	logic [sfs_pkg::PICK_W-1:0]       random_pick;

	modport source (output valid, command, frame_value, direction, random_pick, input ready);
	modport sink (input valid, command, frame_value, direction, random_pick, output ready);
endinterface

@@ rtl/sfs_res_if.sv @@
// sfs_res_if: result channel of the sprite frame sequencer
// depends on sfs_pkg for the field widths
interface sfs_res_if;
	logic                             valid;
	logic                             ready;
	logic [sfs_pkg::SRC_X_W-1:0]      source_x;
	logic [sfs_pkg::ROW_W-1:0]        source_y;
	logic [sfs_pkg::FRAME_W-1:0]      shown_index;

	modport source (output valid, source_x, source_y, shown_index, input ready);
	modport sink (input valid, source_x, source_y, shown_index, output ready);
endinterface

@@ rtl/sfs_anim.sv @@
// sfs_anim: frame counter, delay prescaler and facing row of the sequencer
// depends on sfs_pkg; gives the shown index and row that follow the current beat
module sfs_anim #(
	parameter int unsigned MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sfs_pkg::cfg_t                 cfg,
	input  logic                          step,
	input  logic [sfs_pkg::CMD_W-1:0]     command,
	input  logic [sfs_pkg::FRAME_W-1:0]   frame_value,
	input  logic [sfs_pkg::DIR_W-1:0]     direction,
	input  logic [sfs_pkg::PICK_W-1:0]    random_pick,
	output logic [sfs_pkg::FRAME_W-1:0]   shown_next,
	output logic [sfs_pkg::ROW_W-1:0]     row_next
);

	localparam int unsigned FW = sfs_pkg::FRAME_W;
	localparam int unsigned DW = sfs_pkg::DELAY_W;
	localparam int unsigned RW = sfs_pkg::ROW_W;

	logic [FW-1:0] frame_q;
	logic [DW-1:0] delay_q;
	logic [RW-1:0] row_q;

	logic [FW-1:0] frame_d;
	logic [DW-1:0] delay_d;
	logic [RW-1:0] row_d;

	logic [FW-1:0] n_eff;
	logic [FW-1:0] mid;
	logic [FW:0]   pp_limit;
	logic [FW:0]   frame_inc;
	logic [DW:0]   delay_inc;
	logic          delay_hit;
	logic [FW-1:0] frame_stepped;
	sfs_pkg::facing_t facing;
	logic          facing_ok;

	// effective animation length: at least one, at most the frame limit
	always_comb begin
		if (cfg.frame_count == '0)
			n_eff = FW'(1);
		else if (32'(cfg.frame_count) > 32'(MAX_FRAMES))
			n_eff = FW'(MAX_FRAMES);
		else
			n_eff = cfg.frame_count;
	end

	assign mid       = n_eff - FW'(1);
	assign pp_limit  = {mid, 1'b0};
	assign frame_inc = {1'b0, frame_q} + (FW+1)'(1);
	assign delay_inc = {1'b0, delay_q} + (DW+1)'(1);
	assign delay_hit = delay_inc >= {1'b0, cfg.delay_ticks};

	// counter step by mode
	always_comb begin
		case (cfg.mode)
			sfs_pkg::MODE_LOOP:
				frame_stepped = (frame_inc >= {1'b0, n_eff}) ? '0 : frame_inc[FW-1:0];
			sfs_pkg::MODE_PINGPONG:
				frame_stepped = (frame_inc >= pp_limit) ? '0 : frame_inc[FW-1:0];
			default:
				frame_stepped = (frame_inc >= {1'b0, n_eff}) ? mid : frame_inc[FW-1:0];
		endcase
	end

	// facing chosen by a set direction beat
	always_comb begin
		facing    = sfs_pkg::facing_t'(direction[sfs_pkg::PICK_W-1:0]);
		facing_ok = 1'b0;
		if (!direction[sfs_pkg::DIR_W-1]) begin
			facing_ok = 1'b1;
		end else if (direction == sfs_pkg::DIR_FROM_PICK) begin
			facing    = sfs_pkg::facing_t'(random_pick);
			facing_ok = 1'b1;
		end
	end

	// next state for the command of this beat
	always_comb begin
		frame_d = frame_q;
		delay_d = delay_q;
		row_d   = row_q;
		case (sfs_pkg::cmd_t'(command))
			sfs_pkg::CMD_TICK: begin
				if (cfg.mode != sfs_pkg::MODE_STATIC) begin
					if (delay_hit) begin
						delay_d = '0;
						frame_d = frame_stepped;
					end else begin
						delay_d = delay_inc[DW-1:0];
					end
				end
			end
			sfs_pkg::CMD_SET_FRAME: begin
				frame_d = frame_value;
			end
			sfs_pkg::CMD_RESTART: begin
				frame_d = '0;
				delay_d = '0;
			end
			sfs_pkg::CMD_SET_DIR: begin
				if (cfg.walk && facing_ok) begin
					case (facing)
						sfs_pkg::FACE_UP:    row_d = cfg.row_up;
						sfs_pkg::FACE_LEFT:  row_d = cfg.row_left;
						sfs_pkg::FACE_DOWN:  row_d = cfg.row_down;
						default:             row_d = cfg.row_right;
					endcase
				end
			end
			default: begin
				frame_d = frame_q;
			end
		endcase
	end

	// shown index: distance from the middle in ping-pong mode
	always_comb begin
		if (cfg.mode == sfs_pkg::MODE_PINGPONG)
			shown_next = (mid >= frame_d) ? (mid - frame_d) : (frame_d - mid);
		else
			shown_next = frame_d;
	end

	assign row_next = row_d;

	// animation state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			delay_q <= '0;
			row_q   <= '0;
		end else if (step) begin
			frame_q <= frame_d;
			delay_q <= delay_d;
			row_q   <= row_d;
		end
	end

endmodule

@@ rtl/sprite_frame_sequencer.sv @@
// sprite_frame_sequencer: a beat passes stage one and two to its result; one beat accepted
// and one result given per cycle while res.ready is high, the result register decoupling
// the two channels. the frame multiply has a stage of its own after the state update.
// reset clears the frame counter, prescaler and facing row, all registers read zero
// except frame_count, which reads one. depends on sfs_pkg, sfs_cmd_if, sfs_res_if, sfs_anim
module sprite_frame_sequencer #(
	parameter int unsigned MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [sfs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfs_pkg::CFG_DATA_W-1:0]    cfg_data,
	sfs_cmd_if.sink                           cmd,
	sfs_res_if.source                         res
);

	localparam int unsigned FW = sfs_pkg::FRAME_W;
	localparam int unsigned RW = sfs_pkg::ROW_W;
	localparam int unsigned WW = sfs_pkg::WIDTH_W;
	localparam int unsigned XW = sfs_pkg::SRC_X_W;

	sfs_pkg::cfg_t cfg_q;

	logic          accept;
	logic          adv_s2;
	logic [FW-1:0] shown_next;
	logic [RW-1:0] row_next;

	logic          valid_s1;
	logic [FW-1:0] shown_s1;
	logic [RW-1:0] row_s1;

	logic          valid_s2;
	logic [XW-1:0] x_s2;
	logic [RW-1:0] y_s2;
	logic [FW-1:0] shown_s2;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width <= '0;
			cfg_q.mode        <= sfs_pkg::MODE_LOOP;
			cfg_q.walk        <= 1'b0;
			cfg_q.frame_count <= FW'(1);
			cfg_q.delay_ticks <= '0;
			cfg_q.row_up      <= '0;
			cfg_q.row_down    <= '0;
			cfg_q.row_left    <= '0;
			cfg_q.row_right   <= '0;
		end else if (cfg_write) begin
			case (sfs_pkg::reg_idx_t'(cfg_index))
				sfs_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width <= cfg_data[WW-1:0];
				sfs_pkg::REG_ANIM_CONTROL: begin
					cfg_q.mode <= sfs_pkg::mode_t'(cfg_data[1:0]);
					cfg_q.walk <= cfg_data[2];
				end
				sfs_pkg::REG_FRAME_COUNT:  cfg_q.frame_count <= cfg_data[FW-1:0];
				sfs_pkg::REG_DELAY_TICKS:  cfg_q.delay_ticks <= cfg_data;
				sfs_pkg::REG_ROW_UP:       cfg_q.row_up <= cfg_data;
				sfs_pkg::REG_ROW_DOWN:     cfg_q.row_down <= cfg_data;
				sfs_pkg::REG_ROW_LEFT:     cfg_q.row_left <= cfg_data;
				default:                   cfg_q.row_right <= cfg_data;
			endcase
		end
	end

	// handshake: stage one refills while the result stage drains
	assign adv_s2    = valid_s1 && (!valid_s2 || res.ready);
	assign cmd.ready = !valid_s1 || !valid_s2 || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	sfs_anim #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_anim (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.step        (accept),
		.command     (cmd.command),
		.frame_value (cmd.frame_value),
		.direction   (cmd.direction),
		.random_pick (cmd.random_pick),
		.shown_next  (shown_next),
		.row_next    (row_next)
	);

	// stage one: shown index and row after the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			shown_s1 <= shown_next;
			row_s1   <= row_next;
		end
	end

	// stage two: source x from the frame width multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			x_s2     <= XW'(cfg_q.frame_width) * XW'(shown_s1);
			y_s2     <= row_s1;
			shown_s2 <= shown_s1;
		end
	end

	assign res.valid       = valid_s2;
	assign res.source_x    = x_s2;
	assign res.source_y    = y_s2;
	assign res.shown_index = shown_s2;

endmodule
